[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define TVS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

[rtl/core/tvs_pkg.sv]
// ---------------------------------------------------------------------------
// Trilinear volume sampler package
// Default sizes, command codes and configuration register indices.
// ---------------------------------------------------------------------------
package tvs_pkg;

  localparam int AXIS_SIZE_DEF  = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int VALUE_BITS_DEF = 16;

  localparam int SIZE_RESET = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = CFG_IDX_W'(2);

  localparam int NUM_AXES  = 3;
  localparam int NUM_BANKS = 8;

endpackage

[rtl/core/tvs_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ---------------------------------------------------------------------------
module tvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/trilinear_volume_sampler.sv]
// ---------------------------------------------------------------------------
// Trilinear volume sampler
// Voxel store in eight parity banks with a six-stage interpolation pipeline.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake               Transaction
//  cfg      in         cfg_we_i                size register write
//  in       in         in_valid_i/in_ready_o   voxel write or sample request
//  out      out        out_valid_o/out_ready_i interpolated sample
//
// One transaction is accepted per cycle unless the full pipeline is stalled.
// A sample passes the input, clamp, bank read and three lerp registers. Each
// stage holds its item only while the next stage is full and stalled, so
// bubbles are squeezed out and a stalled output still lets items in. Reset
// clears the valid bits and sets each size to its reset value, but not the
// voxel banks; the user must write a voxel before it is read (not enforced).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trilinear_volume_sampler #(
  parameter int AXIS_SIZE  = tvs_pkg::AXIS_SIZE_DEF,
  parameter int FRAC_BITS  = tvs_pkg::FRAC_BITS_DEF,
  parameter int VALUE_BITS = tvs_pkg::VALUE_BITS_DEF,
  localparam int IW = $clog2(AXIS_SIZE),
  localparam int SW = $clog2(AXIS_SIZE + 1),
  localparam int PW = SW + FRAC_BITS,
  localparam int OW = VALUE_BITS + FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SW-1:0]                  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [IW-1:0]                  voxel_x_i,
  input  logic [IW-1:0]                  voxel_y_i,
  input  logic [IW-1:0]                  voxel_z_i,
  input  logic signed [VALUE_BITS-1:0]   voxel_value_i,
  input  logic [PW-1:0]                  pos_x_i,
  input  logic [PW-1:0]                  pos_y_i,
  input  logic [PW-1:0]                  pos_z_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [OW-1:0]           sample_value_o
);

  import tvs_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VB  = VALUE_BITS;
  localparam int HW  = ($clog2((AXIS_SIZE + 1) / 2) > 0) ? $clog2((AXIS_SIZE + 1) / 2) : 1;
  localparam int AW  = 3 * HW;
  localparam int XL  = VB + F;
  localparam int YL  = VB + 2 * F;
  localparam int ZL  = VB + 3 * F;
  localparam int TOP_RST = ((SIZE_RESET < AXIS_SIZE) ? SIZE_RESET : AXIS_SIZE) - 1;
  localparam logic [ZL-1:0] RND_HALF = ZL'(1) << (2 * F - 1);

  // Configuration: the top index in use along each axis.
  logic [IW-1:0] top_q [NUM_AXES];
  logic [IW-1:0] cfg_top;

  // Stage enables and valid bits.
  logic en_a, en_b, en_c, en_d, en_e, en_f;
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q;

  // Stage A: accepted transaction.
  logic                 a_cmd_q;
  logic [IW-1:0]        a_vox_q [NUM_AXES];
  logic [VB-1:0]        a_val_q;
  logic [PW-1:0]        a_pos_q [NUM_AXES];

  // Stage B: clamped indices or write coordinates.
  logic                 b_cmd_q, b_ok_q;
  logic [IW-1:0]        b_i0_q [NUM_AXES];
  logic                 b_cl_q [NUM_AXES];
  logic [F-1:0]         b_w_q  [NUM_AXES];
  logic [VB-1:0]        b_val_q;
  logic                 b_ok_d;
  logic [IW-1:0]        b_i0_d [NUM_AXES];
  logic                 b_cl_d [NUM_AXES];

  // Stage C: bank read data and corner selection controls.
  logic                 c_par_q [NUM_AXES];
  logic                 c_cl_q  [NUM_AXES];
  logic [F-1:0]         c_w_q   [NUM_AXES];
  logic [VB-1:0]        rd [NUM_BANKS];

  // Stages D, E and F: lerps along x, y and z.
  logic signed [XL-1:0] d_x_q [4];
  logic signed [XL-1:0] d_x_d [4];
  logic [F-1:0]         d_wy_q, d_wz_q;
  logic signed [YL-1:0] e_y_q [2];
  logic signed [YL-1:0] e_y_d [2];
  logic [F-1:0]         e_wz_q;
  logic signed [OW-1:0] f_val_q, f_val_d;

  // Bank access.
  logic [HW-1:0]        odd_h  [NUM_AXES];
  logic [HW-1:0]        even_h [NUM_AXES];
  logic [AW-1:0]        raddr  [NUM_BANKS];
  logic [AW-1:0]        waddr;
  logic [2:0]           wbank;
  logic                 wr_fire;
  logic [NUM_BANKS-1:0] bank_we;

  assign en_f = !f_v_q || out_ready_i;
  assign en_e = !e_v_q || en_f;
  assign en_d = !d_v_q || en_e;
  assign en_c = !c_v_q || en_d;
  assign en_b = !b_v_q || en_c;
  assign en_a = !a_v_q || en_b;

  assign in_ready_o     = en_a;
  assign out_valid_o    = f_v_q;
  assign sample_value_o = f_val_q;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_top = '0;
    end else if (cfg_data_i > SW'(AXIS_SIZE)) begin
      cfg_top = IW'(AXIS_SIZE - 1);
    end else begin
      cfg_top = IW'(cfg_data_i - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        top_q[k] <= IW'(TOP_RST);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_SIZE: top_q[0] <= cfg_top;
        CFG_Y_SIZE: top_q[1] <= cfg_top;
        CFG_Z_SIZE: top_q[2] <= cfg_top;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_v_q <= in_valid_i;
      end
      if (en_b) begin
        b_v_q <= a_v_q;
      end
      if (en_c) begin
        c_v_q <= b_v_q && (b_cmd_q == CMD_SAMPLE);
      end
      if (en_d) begin
        d_v_q <= c_v_q;
      end
      if (en_e) begin
        e_v_q <= d_v_q;
      end
      if (en_f) begin
        f_v_q <= e_v_q;
      end
    end
  end

  // Clamp each axis, or pass write coordinates through and check their range.
  always_comb begin
    logic [SW-1:0] ip;
    logic [IW-1:0] i0;
    b_ok_d = 1'b1;
    for (int k = 0; k < NUM_AXES; k++) begin
      ip = a_pos_q[k][PW-1:F];
      i0 = (ip > SW'(top_q[k])) ? top_q[k] : ip[IW-1:0];
      if (a_cmd_q == CMD_WRITE) begin
        b_i0_d[k] = a_vox_q[k];
      end else begin
        b_i0_d[k] = i0;
      end
      b_cl_d[k] = (i0 == top_q[k]);
      if ((IW + 1)'(a_vox_q[k]) >= (IW + 1)'(AXIS_SIZE)) begin
        b_ok_d = 1'b0;
      end
    end
  end

  // Bank addresses: odd banks take the odd one of i0 and i0 + 1, even
  // banks the even one.
  always_comb begin
    logic [HW-1:0] h [NUM_AXES];
    for (int k = 0; k < NUM_AXES; k++) begin
      odd_h[k]  = HW'(b_i0_q[k] >> 1);
      even_h[k] = HW'(({1'b0, b_i0_q[k]} + (IW + 1)'(1)) >> 1);
    end
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        h[k] = b[k] ? odd_h[k] : even_h[k];
      end
      raddr[b] = {h[2], h[1], h[0]};
    end
  end

  assign waddr   = {odd_h[2], odd_h[1], odd_h[0]};
  assign wbank   = {b_i0_q[2][0], b_i0_q[1][0], b_i0_q[0][0]};
  assign wr_fire = en_c && b_v_q && (b_cmd_q == CMD_WRITE) && b_ok_q;

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    assign bank_we[g] = wr_fire && (wbank == 3'(g));

    tvs_ram #(
      .WIDTH (VB),
      .DEPTH (2 ** AW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (waddr),
      .wdata_i (b_val_q),
      .re_i    (en_c),
      .raddr_i (raddr[g]),
      .rdata_o (rd[g])
    );
  end

  // Corner selection and lerps along x.
  always_comb begin
    logic [2:0]             sel;
    logic signed [VB-1:0]   corner [NUM_BANKS];
    logic signed [VB:0]     lo_e, hi_e, diff;
    logic signed [F:0]      ws;
    logic signed [XL+1:0]   base, prod, sum;
    for (int k = 0; k < NUM_BANKS; k++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sel[a] = c_par_q[a] ^ (k[a] & !c_cl_q[a]);
      end
      corner[k] = $signed(rd[sel]);
    end
    ws = $signed({1'b0, c_w_q[0]});
    for (int j = 0; j < 4; j++) begin
      lo_e     = corner[2 * j];
      hi_e     = corner[2 * j + 1];
      diff     = hi_e - lo_e;
      prod     = diff * ws;
      base     = corner[2 * j];
      sum      = (base <<< F) + prod;
      d_x_d[j] = sum[XL-1:0];
    end
  end

  always_comb begin
    logic signed [XL:0]     lo_e, hi_e, diff;
    logic signed [F:0]      ws;
    logic signed [YL+1:0]   base, prod, sum;
    ws = $signed({1'b0, d_wy_q});
    for (int m = 0; m < 2; m++) begin
      lo_e     = d_x_q[2 * m];
      hi_e     = d_x_q[2 * m + 1];
      diff     = hi_e - lo_e;
      prod     = diff * ws;
      base     = d_x_q[2 * m];
      sum      = (base <<< F) + prod;
      e_y_d[m] = sum[YL-1:0];
    end
  end

  // Lerp along z, then round half up to the output fraction.
  always_comb begin
    logic signed [YL:0]     lo_e, hi_e, diff;
    logic signed [F:0]      ws;
    logic signed [ZL+1:0]   base, prod, sum;
    logic [ZL-1:0]          rnd;
    ws      = $signed({1'b0, e_wz_q});
    lo_e    = e_y_q[0];
    hi_e    = e_y_q[1];
    diff    = hi_e - lo_e;
    prod    = diff * ws;
    base    = e_y_q[0];
    sum     = (base <<< F) + prod;
    rnd     = sum[ZL-1:0] + RND_HALF;
    f_val_d = $signed(rnd[ZL-1:2*F]);
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_cmd_q    <= cmd_i;
      a_vox_q[0] <= voxel_x_i;
      a_vox_q[1] <= voxel_y_i;
      a_vox_q[2] <= voxel_z_i;
      a_val_q    <= voxel_value_i;
      a_pos_q[0] <= pos_x_i;
      a_pos_q[1] <= pos_y_i;
      a_pos_q[2] <= pos_z_i;
    end
    if (en_b) begin
      b_cmd_q <= a_cmd_q;
      b_ok_q  <= b_ok_d;
      b_val_q <= a_val_q;
      for (int k = 0; k < NUM_AXES; k++) begin
        b_i0_q[k] <= b_i0_d[k];
        b_cl_q[k] <= b_cl_d[k];
        b_w_q[k]  <= a_pos_q[k][F-1:0];
      end
    end
    if (en_c) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        c_par_q[k] <= b_i0_q[k][0];
        c_cl_q[k]  <= b_cl_q[k];
        c_w_q[k]   <= b_w_q[k];
      end
    end
    if (en_d) begin
      d_x_q  <= d_x_d;
      d_wy_q <= c_w_q[1];
      d_wz_q <= c_w_q[2];
    end
    if (en_e) begin
      e_y_q  <= e_y_d;
      e_wz_q <= d_wz_q;
    end
    if (en_f) begin
      f_val_q <= f_val_d;
    end
  end

  `TVS_ASSERT(a_stall_needs_item, !in_ready_o |-> a_v_q, "Input stalled with stage A empty.")
  `TVS_ASSERT_NEVER(a_one_bank_write, $countones(bank_we) > 1, "Voxel written to two banks.")
  `TVS_ASSERT(a_out_from_stage_e, $rose(f_v_q) |-> $past(e_v_q), "Result without a source item.")
  `TVS_ASSERT(a_c_only_samples, c_v_q && !$past(c_v_q) |-> $past(b_v_q) && ($past(b_cmd_q) == CMD_SAMPLE), "Write item entered the interpolation stages.")

endmodule

[verif/trilinear_volume_sampler_test.sv]
// ----------------------------------------------------------------------------
// Trilinear volume sampler testbench
// Loads voxels and requests samples through the valid/ready input channel.
// Each sample is predicted from a copy of the voxel store and the size
// registers, then compared with the result on the output channel. The
// stimulus covers directed extremes, size registers at and beyond their
// limits, a long output hold-off and random traffic under set and random sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trilinear_volume_sampler_test;
  import tvs_pkg::*;

  localparam int AXIS  = AXIS_SIZE_DEF;
  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int VBITS = VALUE_BITS_DEF;
  localparam int IW    = $clog2(AXIS);
  localparam int SW    = $clog2(AXIS + 1);
  localparam int PW    = SW + FRAC;
  localparam int OW    = VBITS + FRAC;
  localparam int DEPTH = AXIS * AXIS * AXIS;

  localparam int PIPE_LATENCY  = 6;
  localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY + 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int RANDOM_PHASES = 10;

  typedef enum logic [1:0] {RX_ALWAYS, RX_SPARSE, RX_DENSE, RX_PERIODIC} rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_X_SIZE;
  logic [SW-1:0]         cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  cmd_i         = CMD_WRITE;
  logic [IW-1:0]         voxel_x_i     = '0;
  logic [IW-1:0]         voxel_y_i     = '0;
  logic [IW-1:0]         voxel_z_i     = '0;
  logic signed [VBITS-1:0] voxel_value_i = '0;
  logic [PW-1:0]         pos_x_i       = '0;
  logic [PW-1:0]         pos_y_i       = '0;
  logic [PW-1:0]         pos_z_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic signed [OW-1:0]  sample_value_o;

  logic signed [VBITS-1:0] voxel_model [DEPTH];
  bit                      voxel_written [DEPTH];
  logic [SW-1:0]           size_x = SW'(SIZE_RESET);
  logic [SW-1:0]           size_y = SW'(SIZE_RESET);
  logic [SW-1:0]           size_z = SW'(SIZE_RESET);
  logic signed [OW-1:0]    pending_samples [$];
  logic signed [OW-1:0]    expected_value;

  int unsigned items_sent       = 0;
  int unsigned writes_sent      = 0;
  int unsigned samples_checked  = 0;
  int unsigned settings_applied = 0;
  int unsigned fail_count       = 0;
  int unsigned idle_cycles      = 0;
  int unsigned burst_left       = 0;
  bit          steady           = 1'b0;
  bit          hold_request     = 1'b0;
  rx_mode_e    rx_mode          = RX_ALWAYS;
  int unsigned rx_left          = 0;
  int unsigned rx_tick          = 0;

  trilinear_volume_sampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .voxel_x_i      (voxel_x_i),
    .voxel_y_i      (voxel_y_i),
    .voxel_z_i      (voxel_z_i),
    .voxel_value_i  (voxel_value_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_size(logic [SW-1:0] reg_val);
    if (reg_val == 0) return 1;
    if (reg_val > AXIS) return AXIS;
    return reg_val;
  endfunction

  function automatic void axis_split(input logic [PW-1:0] pos, input logic [SW-1:0] reg_val,
                                     output int unsigned lo_i, output int unsigned hi_i,
                                     output int unsigned frac);
    int unsigned top;
    int unsigned ip;
    top  = eff_size(reg_val) - 1;
    ip   = pos >> FRAC;
    lo_i = (ip > top) ? top : ip;
    hi_i = (lo_i + 1 > top) ? top : lo_i + 1;
    frac = pos[FRAC-1:0];
  endfunction

  function automatic int unsigned voxel_index(int unsigned x, int unsigned y, int unsigned z);
    return (z * AXIS + y) * AXIS + x;
  endfunction

  // Exact weighted sum of the eight corners, rounded half up to FRAC bits.
  function automatic logic signed [OW-1:0] interpolate_at(logic [PW-1:0] px, logic [PW-1:0] py,
                                                          logic [PW-1:0] pz);
    int unsigned xi [2];
    int unsigned yi [2];
    int unsigned zi [2];
    int unsigned wx [2];
    int unsigned wy [2];
    int unsigned wz [2];
    int unsigned fx, fy, fz;
    int          a, b, c;
    longint      acc;
    axis_split(px, size_x, xi[0], xi[1], fx);
    axis_split(py, size_y, yi[0], yi[1], fy);
    axis_split(pz, size_z, zi[0], zi[1], fz);
    wx[0] = (1 << FRAC) - fx;
    wx[1] = fx;
    wy[0] = (1 << FRAC) - fy;
    wy[1] = fy;
    wz[0] = (1 << FRAC) - fz;
    wz[1] = fz;
    acc = 0;
    for (c = 0; c < 2; c++)
      for (b = 0; b < 2; b++)
        for (a = 0; a < 2; a++)
          acc += longint'(voxel_model[voxel_index(xi[a], yi[b], zi[c])]) *
                 longint'(wx[a] * wy[b] * wz[c]);
    acc += longint'(1) << (2 * FRAC - 1);
    acc = acc >>> (2 * FRAC);
    return acc[OW-1:0];
  endfunction

  function automatic logic [PW-1:0] pick_coord(int unsigned eff);
    logic [PW-1:0] p;
    int unsigned   win;
    p = PW'($urandom);
    case ($urandom_range(0, 9))
      0: ;
      1: p[PW-1:FRAC] = SW'($urandom_range(eff - 1, (1 << SW) - 1));
      2: begin
        p[PW-1:FRAC] = SW'($urandom_range(0, eff - 1));
        p[FRAC-1:0]  = $urandom_range(0, 1) ? {FRAC{1'b1}} : {FRAC{1'b0}};
      end
      default: begin
        win = (eff < 4) ? eff : 4;
        p[PW-1:FRAC] = SW'($urandom_range(0, win - 1));
      end
    endcase
    return p;
  endfunction

  task automatic send_item(input logic cmd, input logic [IW-1:0] vx, input logic [IW-1:0] vy,
                           input logic [IW-1:0] vz, input logic signed [VBITS-1:0] val,
                           input logic [PW-1:0] px, input logic [PW-1:0] py,
                           input logic [PW-1:0] pz);
    int unsigned gap;
    int unsigned idx;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    voxel_x_i     <= vx;
    voxel_y_i     <= vy;
    voxel_z_i     <= vz;
    voxel_value_i <= val;
    pos_x_i       <= px;
    pos_y_i       <= py;
    pos_z_i       <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      idx = voxel_index(vx, vy, vz);
      voxel_model[idx]   = val;
      voxel_written[idx] = 1'b1;
      writes_sent++;
    end else begin
      pending_samples.push_back(interpolate_at(px, py, pz));
    end
  endtask

  task automatic write_voxel(input int unsigned x, input int unsigned y, input int unsigned z,
                             input logic signed [VBITS-1:0] val);
    send_item(CMD_WRITE, IW'(x), IW'(y), IW'(z), val, PW'($urandom), PW'($urandom),
              PW'($urandom));
  endtask

  task automatic sample_at(input logic [PW-1:0] px, input logic [PW-1:0] py,
                           input logic [PW-1:0] pz);
    send_item(CMD_SAMPLE, IW'($urandom), IW'($urandom), IW'($urandom), VBITS'($urandom),
              px, py, pz);
  endtask

  // Writes every corner not yet loaded; with refresh, sometimes rewrites a loaded one
  // just before the sample so that the read follows the write closely.
  task automatic sample_in_volume(input logic [PW-1:0] px, input logic [PW-1:0] py,
                                  input logic [PW-1:0] pz, input bit refresh);
    int unsigned xi [2];
    int unsigned yi [2];
    int unsigned zi [2];
    int unsigned fx, fy, fz;
    int          a, b, c;
    axis_split(px, size_x, xi[0], xi[1], fx);
    axis_split(py, size_y, yi[0], yi[1], fy);
    axis_split(pz, size_z, zi[0], zi[1], fz);
    for (c = 0; c < 2; c++)
      for (b = 0; b < 2; b++)
        for (a = 0; a < 2; a++)
          if (!voxel_written[voxel_index(xi[a], yi[b], zi[c])] ||
              (refresh && $urandom_range(0, 7) == 0))
            write_voxel(xi[a], yi[b], zi[c], VBITS'($urandom));
    sample_at(px, py, pz);
  endtask

  task automatic drain_inputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_sizes(input int unsigned x, input int unsigned y, input int unsigned z);
    drain_inputs();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_X_SIZE;
    cfg_data_i <= SW'(x);
    size_x = SW'(x);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_Y_SIZE;
    cfg_data_i <= SW'(y);
    size_y = SW'(y);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_Z_SIZE;
    cfg_data_i <= SW'(z);
    size_z = SW'(z);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic test_corner_extremes();
    int a, b, c;
    for (c = 0; c < 2; c++)
      for (b = 0; b < 2; b++)
        for (a = 0; a < 2; a++)
          write_voxel(a, b, c, ((a ^ b ^ c) == 0) ? 16'sh7FFF : 16'sh8000);
    sample_at(14'h0000, 14'h0000, 14'h0000);
    sample_at(14'h0080, 14'h0080, 14'h0080);
    sample_at(14'h00FF, 14'h00FF, 14'h00FF);
    sample_at(14'h0001, 14'h0001, 14'h0001);
    write_voxel(31, 31, 31, 16'sh7FFF);
    sample_at(14'h3FFF, 14'h3FFF, 14'h3FFF);
    sample_at(14'h1FFF, 14'h1FFF, 14'h1FFF);
    write_voxel(31, 31, 31, 16'sh8000);
    sample_at(14'h1F00, 14'h1F00, 14'h1F00);
  endtask

  task automatic test_size_registers();
    set_sizes(0, 63, 1);
    sample_in_volume(14'h3FFF, 14'h00C8, 14'h2A55, 1'b0);
    sample_in_volume(14'h0080, 14'h1FFF, 14'h0000, 1'b0);
    set_sizes(33, 1, 2);
    sample_in_volume(14'h3FFF, 14'h3FFF, 14'h0180, 1'b0);
    sample_in_volume(14'h1E80, 14'h0040, 14'h00FF, 1'b0);
  endtask

  task automatic test_output_holdoff();
    set_sizes(SIZE_RESET, SIZE_RESET, SIZE_RESET);
    sample_in_volume(14'h0280, 14'h0280, 14'h0280, 1'b0);
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (48)
      sample_at(PW'(2 * 256 + $urandom_range(0, 255)), PW'(2 * 256 + $urandom_range(0, 255)),
                PW'(2 * 256 + $urandom_range(0, 255)));
    steady = 1'b0;
    drain_inputs();
    repeat (8)
      sample_at(PW'(2 * 256 + $urandom_range(0, 255)), PW'(2 * 256 + $urandom_range(0, 255)),
                PW'(2 * 256 + $urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic();
    int          k;
    int unsigned start;
    for (k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0:       set_sizes(SIZE_RESET, SIZE_RESET, SIZE_RESET);
        1:       set_sizes(1, 1, 1);
        2:       set_sizes(0, 0, 0);
        3:       set_sizes(63, 63, 63);
        4:       set_sizes(33, 2, 1);
        5:       set_sizes(5, 32, 1);
        6:       set_sizes(7, 12, 3);
        default: set_sizes($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
      endcase
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / RANDOM_PHASES) begin
        if ($urandom_range(0, 4) == 0)
          write_voxel($urandom_range(0, AXIS - 1), $urandom_range(0, AXIS - 1),
                      $urandom_range(0, AXIS - 1), VBITS'($urandom));
        else
          sample_in_volume(pick_coord(eff_size(size_x)), pick_coord(eff_size(size_y)),
                           pick_coord(eff_size(size_z)), 1'b1);
      end
    end
  endtask

  always begin
    @(negedge clk_i);
    if (hold_request) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_request = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        RX_DENSE:  out_ready_i <= ($urandom_range(0, 7) != 0);
        default:   out_ready_i <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected sample transaction, expected none, actual %0d", $time,
                 sample_value_o);
      end else begin
        expected_value = pending_samples.pop_front();
        samples_checked++;
        if (sample_value_o !== expected_value) begin
          fail_count++;
          $display("%0t: sample_value mismatch, expected %0d, actual %0d", $time,
                   expected_value, sample_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d samples outstanding", $time,
               STALL_LIMIT, pending_samples.size());
      $display("trilinear_volume_sampler_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_extremes();
    test_size_registers();
    test_output_holdoff();
    test_random_traffic();
    drain_inputs();
    $display("Checked %0d samples after %0d voxel writes under %0d size settings,",
             samples_checked, writes_sent, settings_applied);
    $display("including a %0d-cycle output hold-off with the input kept busy.", HOLD_CYCLES);
    if (fail_count == 0)
      $display("trilinear_volume_sampler_test OK");
    else
      $display("trilinear_volume_sampler_test NOT OK");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tvs_pkg.sv
rtl/core/tvs_ram.sv
rtl/core/trilinear_volume_sampler.sv
verif/trilinear_volume_sampler_test.sv
